/* rtl/core/kcq_pkg.sv */
package kcq_pkg;

    localparam int unsigned SampleWidth   = 12;
    localparam int unsigned DebounceWidth = 8;
    localparam int unsigned HoldWidth     = 16;
    localparam int unsigned SettleWidth   = 16;
    localparam int unsigned CfgDataWidth  = 16;
    localparam int unsigned CfgIndexWidth = 3;

    // Register indexes on the configuration port.
    localparam logic [CfgIndexWidth-1:0] RegMidKeyLow    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] RegMidKeyHigh   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] RegLowKeyHigh   = 3'd2;
    localparam logic [CfgIndexWidth-1:0] RegDebounceTick = 3'd3;
    localparam logic [CfgIndexWidth-1:0] RegHoldTicks    = 3'd4;
    localparam logic [CfgIndexWidth-1:0] RegSettleTicks  = 3'd5;

    // Register reset values.
    localparam logic [SampleWidth-1:0]   MidKeyLowReset    = 12'd1948;
    localparam logic [SampleWidth-1:0]   MidKeyHighReset   = 12'd2148;
    localparam logic [SampleWidth-1:0]   LowKeyHighReset   = 12'd200;
    localparam logic [DebounceWidth-1:0] DebounceReset     = 8'd100;
    localparam logic [HoldWidth-1:0]     HoldReset         = 16'd5000;
    localparam logic [SettleWidth-1:0]   SettleReset       = 16'd2000;

    typedef enum logic [1:0] {
        CHG_NONE     = 2'd0,
        CHG_CHARGING = 2'd1,
        CHG_FULL     = 2'd2
    } charger_state_t;

    typedef struct packed {
        logic                   sleep_mode;
        logic                   key_pin;
        logic [SampleWidth-1:0] key_sample;
        logic                   switch_pin;
        logic                   charge_pin;
        logic                   standby_pin;
    } qual_in_t;

    typedef struct packed {
        logic switch_held;
        logic charge_full;
        logic usb_present;
        logic key_b_pressed;
        logic key_a_pressed;
    } qual_out_t;

    typedef struct packed {
        logic                     wr_en;
        logic [CfgIndexWidth-1:0] index;
        logic [CfgDataWidth-1:0]  data;
    } cfg_write_t;

endpackage

/* rtl/core/kcq_qualifier.sv */
module kcq_qualifier (
    input  logic                aclk,
    input  logic                aresetn,
    input  kcq_pkg::cfg_write_t cfg,
    input  logic                item_accept,
    input  kcq_pkg::qual_in_t   item_in,
    output kcq_pkg::qual_out_t  item_out
);
    import kcq_pkg::*;

    logic [SampleWidth-1:0]   mid_key_low_reg;
    logic [SampleWidth-1:0]   mid_key_high_reg;
    logic [SampleWidth-1:0]   low_key_high_reg;
    logic [DebounceWidth-1:0] debounce_ticks_reg;
    logic [HoldWidth-1:0]     hold_ticks_reg;
    logic [SettleWidth-1:0]   settle_ticks_reg;

    logic [DebounceWidth-1:0] key_a_count_reg, key_a_count_next;
    logic [DebounceWidth-1:0] key_b_count_reg, key_b_count_next;
    logic [HoldWidth-1:0]     switch_count_reg, switch_count_next;
    logic [SettleWidth-1:0]   settle_count_reg, settle_count_next;
    charger_state_t           last_state_reg, last_state_next;
    qual_out_t                flags_reg, flags_next;

    logic                     press_a;
    logic                     press_b;
    logic [DebounceWidth:0]   key_a_sum;
    logic [DebounceWidth:0]   key_b_sum;
    logic [HoldWidth:0]       switch_sum;
    logic [SettleWidth:0]     settle_sum;
    charger_state_t           cur_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_key_low_reg    <= MidKeyLowReset;
            mid_key_high_reg   <= MidKeyHighReset;
            low_key_high_reg   <= LowKeyHighReset;
            debounce_ticks_reg <= DebounceReset;
            hold_ticks_reg     <= HoldReset;
            settle_ticks_reg   <= SettleReset;
        end else if (cfg.wr_en) begin
            unique case (cfg.index)
                RegMidKeyLow:    mid_key_low_reg    <= cfg.data[SampleWidth-1:0];
                RegMidKeyHigh:   mid_key_high_reg   <= cfg.data[SampleWidth-1:0];
                RegLowKeyHigh:   low_key_high_reg   <= cfg.data[SampleWidth-1:0];
                RegDebounceTick: debounce_ticks_reg <= cfg.data[DebounceWidth-1:0];
                RegHoldTicks:    hold_ticks_reg     <= cfg.data[HoldWidth-1:0];
                RegSettleTicks:  settle_ticks_reg   <= cfg.data[SettleWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        key_a_count_next  = key_a_count_reg;
        key_b_count_next  = key_b_count_reg;
        switch_count_next = switch_count_reg;
        settle_count_next = settle_count_reg;
        last_state_next   = last_state_reg;
        flags_next        = flags_reg;

        press_a = (item_in.key_sample >= mid_key_low_reg) &&
                  (item_in.key_sample <= mid_key_high_reg);
        press_b = item_in.sleep_mode ? !item_in.key_pin
                                     : (item_in.key_sample <= low_key_high_reg);

        key_a_sum  = {1'b0, key_a_count_reg} + 1'b1;
        key_b_sum  = {1'b0, key_b_count_reg} + 1'b1;
        switch_sum = {1'b0, switch_count_reg} + 1'b1;
        settle_sum = {1'b0, settle_count_reg} + 1'b1;

        // Key A keeps its count and flag while asleep.
        if (!item_in.sleep_mode) begin
            if (press_a) begin
                if (key_a_sum >= {1'b0, debounce_ticks_reg}) begin
                    key_a_count_next         = debounce_ticks_reg;
                    flags_next.key_a_pressed = 1'b1;
                end else begin
                    key_a_count_next = key_a_sum[DebounceWidth-1:0];
                end
            end else begin
                key_a_count_next         = '0;
                flags_next.key_a_pressed = 1'b0;
            end
        end

        if (press_b) begin
            if (key_b_sum >= {1'b0, debounce_ticks_reg}) begin
                key_b_count_next         = debounce_ticks_reg;
                flags_next.key_b_pressed = 1'b1;
            end else begin
                key_b_count_next = key_b_sum[DebounceWidth-1:0];
            end
        end else begin
            key_b_count_next         = '0;
            flags_next.key_b_pressed = 1'b0;
        end

        // The switch flag clears only once the integrator has drained to zero.
        if (item_in.switch_pin) begin
            if (switch_sum >= {1'b0, hold_ticks_reg}) begin
                switch_count_next      = hold_ticks_reg;
                flags_next.switch_held = 1'b1;
            end else begin
                switch_count_next = switch_sum[HoldWidth-1:0];
            end
        end else if (switch_count_reg != '0) begin
            switch_count_next = switch_count_reg - 1'b1;
        end else begin
            flags_next.switch_held = 1'b0;
        end

        if (item_in.charge_pin && !item_in.standby_pin) begin
            cur_state = CHG_FULL;
        end else if (!item_in.charge_pin && item_in.standby_pin) begin
            cur_state = CHG_CHARGING;
        end else begin
            cur_state = CHG_NONE;
        end

        if (cur_state == last_state_reg) begin
            if (settle_sum >= {1'b0, settle_ticks_reg}) begin
                settle_count_next = settle_ticks_reg;
                unique case (cur_state)
                    CHG_FULL: begin
                        flags_next.usb_present = 1'b1;
                        flags_next.charge_full = 1'b1;
                    end
                    CHG_CHARGING: begin
                        flags_next.usb_present = 1'b1;
                        flags_next.charge_full = 1'b0;
                    end
                    default: begin
                        flags_next.usb_present = 1'b0;
                        flags_next.charge_full = 1'b0;
                    end
                endcase
            end else begin
                settle_count_next = settle_sum[SettleWidth-1:0];
            end
        end else begin
            settle_count_next = '0;
            last_state_next   = cur_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_a_count_reg  <= '0;
            key_b_count_reg  <= '0;
            switch_count_reg <= '0;
            settle_count_reg <= '0;
            last_state_reg   <= CHG_NONE;
            flags_reg        <= '0;
        end else if (item_accept) begin
            key_a_count_reg  <= key_a_count_next;
            key_b_count_reg  <= key_b_count_next;
            switch_count_reg <= switch_count_next;
            settle_count_reg <= settle_count_next;
            last_state_reg   <= last_state_next;
            flags_reg        <= flags_next;
        end
    end

    assign item_out = flags_next;

endmodule

/* rtl/core/key_and_charger_input_qualifier_core.sv */
// Key and charger input qualifier.
//
// The input channel (s_) carries one tick of pin and ADC samples per item;
// the result channel (m_) returns the five qualified flags of that tick.
// Register writes on the cfg_ port take effect at the clock edge where
// cfg_wr_en is high and should only be made while no item is in flight.
//
// An accepted item updates all counters in the same cycle and its result
// is registered into a two-entry result buffer, which lets the block take
// a new item while one result waits. One item is accepted per cycle while
// s_tready is high; the rate is set by the single counter update per tick.
// Only when both buffer entries are full does s_tready drop, so a stalled
// receiver holds up the input within two items and nothing is lost.
//
// Reset (aresetn low, synchronous) restores the register defaults, clears
// every counter and flag, sets the charger state to none and empties the
// result buffer.
module key_and_charger_input_qualifier_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [kcq_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [kcq_pkg::CfgDataWidth-1:0]    cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // key_pin[0], key_sample[12:1], switch_pin[13], charge_pin[14], standby_pin[15]
    input  logic [15:0]                         s_tdata,
    // sleep_mode[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // key_a_pressed[0], key_b_pressed[1], usb_present[2], charge_full[3],
    // switch_held[4], zero[7:5]
    output logic [7:0]                          m_tdata
);
    import kcq_pkg::*;

    cfg_write_t cfg;
    qual_in_t   item_in;
    qual_out_t  item_out;
    logic       push;
    logic       pop;

    qual_out_t  slot0_reg, slot0_next;
    qual_out_t  slot1_reg, slot1_next;
    logic [1:0] fill_reg, fill_next;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wr_data;

    assign item_in.sleep_mode  = s_tuser;
    assign item_in.key_pin     = s_tdata[0];
    assign item_in.key_sample  = s_tdata[12:1];
    assign item_in.switch_pin  = s_tdata[13];
    assign item_in.charge_pin  = s_tdata[14];
    assign item_in.standby_pin = s_tdata[15];

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign m_tvalid = (fill_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;

    kcq_qualifier u_qualifier (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item_accept (push),
        .item_in     (item_in),
        .item_out    (item_out)
    );

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        fill_next  = fill_reg;
        if (push && !pop) begin
            if (fill_reg == 2'd0) begin
                slot0_next = item_out;
            end else begin
                slot1_next = item_out;
            end
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            slot0_next = slot1_reg;
            fill_next  = fill_reg - 2'd1;
        end else if (pop && push) begin
            // Both at once only happens with one entry held.
            slot0_next = item_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_tdata = {3'b000, slot0_reg.switch_held, slot0_reg.charge_full,
                      slot0_reg.usb_present, slot0_reg.key_b_pressed,
                      slot0_reg.key_a_pressed};

endmodule
